// ----- src/apsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// All-to-all pairwise peer schedule: shared package
// Payload types, register indexes, status codes and limits.
// ----------------------------------------------------------------------------
package apsu_pkg;

    localparam int MAX_RANKS = 256;
    localparam int MAX_LINKS = 16;

    localparam logic [2:0] CFG_RANK_COUNT  = 3'd0;
    localparam logic [2:0] CFG_MESH_SIZE   = 3'd1;
    localparam logic [2:0] CFG_OWN_RANK    = 3'd2;
    localparam logic [2:0] CFG_LINK_COUNT  = 3'd3;
    localparam logic [2:0] CFG_SLICE_BYTES = 3'd4;
    localparam logic [2:0] CFG_INPUT_BASE  = 3'd5;
    localparam logic [2:0] CFG_OUTPUT_BASE = 3'd6;
    localparam logic [2:0] CFG_INPUT_BYTES = 3'd7;

    localparam logic [2:0] ST_SEND  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_BYE   = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    // Reciprocal scale for the micro round split.
    localparam int RECIP_SHIFT = 20;

    typedef struct packed {
        logic [15:0] step_index;
        logic [3:0]  link_index;
        logic [47:0] remote_output_bytes;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  peer_rank;
        logic [39:0] chunk_bytes;
        logic [47:0] send_src_offset;
        logic [47:0] send_dst_offset;
        logic [47:0] recv_offset;
    } t_out;

    typedef struct packed {
        logic bad;
        logic idle;
        logic bye;
    } t_flags;

endpackage

// ----- src/apsu_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of a 41-bit dividend by a 9-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module apsu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [40:0] i_dividend,
    input  logic [8:0]  i_divisor,
    output logic        o_done,
    output logic [40:0] o_quotient,
    output logic [8:0]  o_remainder
);
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [40:0] r_q;
    logic [8:0]  r_rem;
    logic [8:0]  r_dvs;
    logic [9:0]  n_trial;
    logic        n_ge;

    assign n_trial = {r_rem, r_q[40]};
    assign n_ge    = n_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= 6'd41;
            r_done <= 1'b0;
        end else if (r_cnt != 6'd0) begin
            r_cnt  <= r_cnt - 6'd1;
            r_done <= (r_cnt == 6'd1);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != 6'd0) begin
            r_q   <= {r_q[39:0], n_ge};
            r_rem <= n_ge ? 9'(n_trial - {1'b0, r_dvs}) : n_trial[8:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;
endmodule

// ----- src/alltoall_pairwise_peer_schedule_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// All-to-all pairwise peer schedule unit
// Finds the peer, chunk size and byte offsets of one (step, link) query.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_stall, i_data) takes one query per
// transaction; the output channel (o_valid, i_stall, o_data) returns one
// result per query, in order. A query can enter every cycle that o_stall is
// low, a sustained rate of one transaction a cycle. The user must write
// registers through i_cfg_we, i_cfg_idx and i_cfg_data only while the unit
// is idle; the block does not enforce it. Each write starts a recompute of
// the derived values (group count, own group, chunk size and round
// reciprocal), four divisions on one shared bit-serial divider, and o_stall
// is held high until it ends. Reset loads the register defaults and their
// derived values at once, with no recompute. On a stalled valid result, the
// whole pipeline holds, the result stays on o_data and o_stall rises.
// ----------------------------------------------------------------------------
module alltoall_pairwise_peer_schedule_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  apsu_pkg::t_in i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output apsu_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [47:0]   i_cfg_data
);
    import apsu_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_GRP  = 3'd1;
    localparam logic [2:0] PH_OWN  = 3'd2;
    localparam logic [2:0] PH_CHK  = 3'd3;
    localparam logic [2:0] PH_RCP  = 3'd4;

    logic [8:0]  r_rank_count, r_mesh_size;
    logic [7:0]  r_own_rank;
    logic [4:0]  r_link_count;
    logic [39:0] r_slice_bytes, r_input_base, r_output_base;
    logic [47:0] r_input_bytes;

    logic [8:0]  r_groups;
    logic        r_grem;
    logic [7:0]  r_my_group, r_my_local;
    logic [39:0] r_chunk;
    logic [20:0] r_recip;
    logic [2:0]  r_phase;
    logic        r_go;

    logic [40:0] n_dividend;
    logic [8:0]  n_divisor;
    logic        w_done;
    logic [40:0] w_quot;
    logic [8:0]  w_rem;

    logic [8:0]  n_rounds;
    logic [9:0]  n_s, n_m;
    logic        n_cfg_bad;
    logic        n_busy, n_en, n_acc;

    apsu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_go),
        .i_dividend  (n_dividend),
        .i_divisor   (n_divisor),
        .o_done      (w_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    always_comb begin
        unique case (r_phase)
            PH_GRP: begin
                n_dividend = {32'd0, r_rank_count};
                n_divisor  = r_mesh_size;
            end
            PH_OWN: begin
                n_dividend = {33'd0, r_own_rank};
                n_divisor  = r_mesh_size;
            end
            PH_CHK: begin
                n_dividend = 41'({1'b0, r_slice_bytes} + {32'd0, r_rank_count} - 41'd1);
                n_divisor  = r_rank_count;
            end
            PH_RCP: begin
                n_dividend = 41'd1 << RECIP_SHIFT;
                n_divisor  = n_rounds;
            end
            default: begin
                n_dividend = '0;
                n_divisor  = '0;
            end
        endcase
    end

    assign n_rounds = (r_groups <= 9'd1) ? 9'd0 :
                      (r_groups[0] ? r_groups : r_groups - 9'd1);
    assign n_s = r_groups[0] ? ({1'b0, r_groups} + 10'd1) : {1'b0, r_groups};
    assign n_m = n_s - 10'd1;
    assign n_cfg_bad = (r_rank_count == 9'd0) || (r_mesh_size == 9'd0) || r_grem ||
                       (r_rank_count > 9'(MAX_RANKS)) || (r_link_count == 5'd0) ||
                       ({27'd0, r_link_count} > 32'(MAX_LINKS));

    // Register file and derived-value sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_count  <= 9'd1;
            r_mesh_size   <= 9'd1;
            r_own_rank    <= '0;
            r_link_count  <= 5'd1;
            r_slice_bytes <= '0;
            r_input_base  <= '0;
            r_output_base <= '0;
            r_input_bytes <= '0;
            r_groups      <= 9'd1;
            r_grem        <= 1'b0;
            r_my_group    <= '0;
            r_my_local    <= '0;
            r_chunk       <= '0;
            r_recip       <= '0;
            r_phase       <= PH_IDLE;
            r_go          <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANK_COUNT:  r_rank_count  <= i_cfg_data[8:0];
                CFG_MESH_SIZE:   r_mesh_size   <= i_cfg_data[8:0];
                CFG_OWN_RANK:    r_own_rank    <= i_cfg_data[7:0];
                CFG_LINK_COUNT:  r_link_count  <= i_cfg_data[4:0];
                CFG_SLICE_BYTES: r_slice_bytes <= i_cfg_data[39:0];
                CFG_INPUT_BASE:  r_input_base  <= i_cfg_data[39:0];
                CFG_OUTPUT_BASE: r_output_base <= i_cfg_data[39:0];
                CFG_INPUT_BYTES: r_input_bytes <= i_cfg_data;
                default: ;
            endcase
            r_phase <= PH_GRP;
            r_go    <= 1'b1;
        end else if (w_done && !r_go) begin
            unique case (r_phase)
                PH_GRP: begin
                    r_groups <= w_quot[8:0];
                    r_grem   <= (w_rem != 9'd0);
                    r_phase  <= PH_OWN;
                    r_go     <= 1'b1;
                end
                PH_OWN: begin
                    r_my_group <= w_quot[7:0];
                    r_my_local <= w_rem[7:0];
                    r_phase    <= PH_CHK;
                    r_go       <= 1'b1;
                end
                PH_CHK: begin
                    r_chunk <= w_quot[39:0];
                    r_phase <= PH_RCP;
                    r_go    <= 1'b1;
                end
                PH_RCP: begin
                    r_recip <= w_quot[20:0];
                    r_phase <= PH_IDLE;
                    r_go    <= 1'b0;
                end
                default: begin
                    r_phase <= PH_IDLE;
                    r_go    <= 1'b0;
                end
            endcase
        end else begin
            r_go <= 1'b0;
        end
    end

    // Query pipeline.
    logic [10:1] r_v;
    t_flags      r_f1, r_f2, r_f3, r_f4, r_f5, r_f6, r_f7, r_f8, r_f9;
    logic [47:0] r_rm1, r_rm2, r_rm3, r_rm4, r_rm5, r_rm6, r_rm7, r_rm8, r_rm9;
    logic [20:0] r_micro1, r_micro2;
    logic [20:0] r_qe2, r_qe3;
    logic [9:0]  r_r3;
    logic [20:0] r_shift4;
    logic [8:0]  r_color4, r_color5;
    logic [8:0]  r_shl5;
    logic [9:0]  r_ppos5;
    logic        r_left5;
    logic [9:0]  r_pg6, r_pl6;
    logic [7:0]  r_peer7, r_peer8, r_peer9;
    logic [47:0] r_pc8, r_oc8;
    logic [48:0] r_src9, r_dst9, r_rcv9;
    t_out        r_out;

    logic [41:0] n_prod2;
    logic [29:0] n_qd3;
    logic [20:0] n_r3;
    logic        n_ge4;
    logic [9:0]  n_t5, n_tt5, n_pos5;
    logic [9:0]  n_g6, n_pl6;
    logic [17:0] n_peer7;
    t_flags      n_f7;
    t_out        n_out;

    assign n_busy = (r_phase != PH_IDLE);
    assign n_en   = !(r_v[10] && i_stall);
    assign o_stall = n_busy || !n_en;
    assign n_acc  = i_valid && !o_stall;

    assign n_prod2 = 42'(r_micro1) * 42'(r_recip);
    assign n_qd3   = 30'(r_qe2) * 30'(n_rounds);
    assign n_r3    = r_micro2 - n_qd3[20:0];
    assign n_ge4   = r_r3 >= {1'b0, n_rounds};

    always_comb begin
        n_t5 = {2'd0, r_my_group} - 10'd1 + {1'b0, r_color4};
        n_tt5 = (n_t5 >= n_m) ? n_t5 - n_m : n_t5;
        n_pos5 = (r_my_group == 8'd0) ? 10'd0 : n_tt5 + 10'd1;
        n_g6 = r_ppos5 - 10'd1 + n_m - {1'b0, r_color5};
        if (n_g6 >= n_m) begin
            n_g6 = n_g6 - n_m;
        end
        if (r_left5) begin
            n_pl6 = {2'd0, r_my_local} + {1'b0, r_shl5};
        end else begin
            n_pl6 = {2'd0, r_my_local} + {1'b0, r_mesh_size} - {1'b0, r_shl5};
        end
        if (n_pl6 >= {1'b0, r_mesh_size}) begin
            n_pl6 = n_pl6 - {1'b0, r_mesh_size};
        end
        n_peer7 = 18'(r_pg6[8:0]) * 18'(r_mesh_size) + 18'(r_pl6);
        n_f7 = r_f6;
        n_f7.bye = r_f6.bye || (r_pg6 >= {1'b0, r_groups});
    end

    always_comb begin
        n_out = '0;
        priority if (r_f9.bad) begin
            n_out.status = ST_BAD;
        end else if (r_f9.idle) begin
            n_out.status      = ST_IDLE;
            n_out.chunk_bytes = r_chunk;
        end else if (r_f9.bye) begin
            n_out.status      = ST_BYE;
            n_out.chunk_bytes = r_chunk;
        end else begin
            n_out.status = ((50'(r_src9) + 50'(r_chunk) > 50'(r_input_bytes)) ||
                            (50'(r_dst9) + 50'(r_chunk) > 50'(r_rm9)))
                           ? ST_RANGE : ST_SEND;
            n_out.peer_rank       = r_peer9;
            n_out.chunk_bytes     = r_chunk;
            n_out.send_src_offset = r_src9[47:0];
            n_out.send_dst_offset = r_dst9[47:0];
            n_out.recv_offset     = r_rcv9[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (n_en) begin
            r_v <= {r_v[9:1], n_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_micro1 <= 21'(i_data.step_index) * 21'(r_link_count) +
                        21'(i_data.link_index);
            r_f1  <= {n_cfg_bad || ({1'b0, i_data.link_index} >= r_link_count),
                      1'b0, 1'b0};
            r_rm1 <= i_data.remote_output_bytes;

            r_micro2 <= r_micro1;
            r_qe2    <= n_prod2[40:20];
            r_f2     <= r_f1;
            r_rm2    <= r_rm1;

            r_qe3 <= r_qe2;
            r_r3  <= n_r3[9:0];
            r_f3  <= r_f2;
            r_rm3 <= r_rm2;

            if (n_rounds == 9'd0) begin
                r_shift4 <= '0;
                r_color4 <= '0;
            end else if (n_ge4) begin
                r_shift4 <= r_qe3 + 21'd1;
                r_color4 <= 9'(r_r3 - {1'b0, n_rounds});
            end else begin
                r_shift4 <= r_qe3;
                r_color4 <= r_r3[8:0];
            end
            r_f4  <= r_f3;
            r_rm4 <= r_rm3;

            r_left5  <= n_pos5 < (n_s >> 1);
            r_ppos5  <= n_s - 10'd1 - n_pos5;
            r_color5 <= r_color4;
            r_shl5   <= r_shift4[8:0];
            r_f5     <= {r_f4.bad, r_shift4 >= {12'd0, r_mesh_size},
                         (r_groups <= 9'd1) || ({1'b0, r_my_group} >= r_groups)};
            r_rm5 <= r_rm4;

            r_pg6  <= (r_ppos5 == 10'd0) ? 10'd0 : n_g6 + 10'd1;
            r_pl6  <= n_pl6;
            r_f6   <= r_f5;
            r_rm6  <= r_rm5;

            r_peer7 <= n_peer7[7:0];
            r_f7    <= n_f7;
            r_rm7   <= r_rm6;

            r_pc8   <= 48'(r_peer7) * 48'(r_chunk);
            r_oc8   <= 48'(r_own_rank) * 48'(r_chunk);
            r_peer8 <= r_peer7;
            r_f8    <= r_f7;
            r_rm8   <= r_rm7;

            r_src9  <= 49'(r_input_base) + 49'(r_pc8);
            r_dst9  <= 49'(r_output_base) + 49'(r_oc8);
            r_rcv9  <= 49'(r_output_base) + 49'(r_pc8);
            r_peer9 <= r_peer8;
            r_f9    <= r_f8;
            r_rm9   <= r_rm8;

            r_out <= n_out;
        end
    end

    assign o_valid = r_v[10];
    assign o_data  = r_out;

    a_busy_stalls : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_busy |-> o_stall) else $error("input taken during recompute");
    a_cfg_stalls : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_stall) else $error("no recompute after register write");
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall) else $error("input taken while output stalled");
endmodule
